FILE: hw/rtl/gpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gait phase generator package
// Widths, register indexes, gait presets, payload types and the microcode
// types shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package gpg_pkg;

	// Fixed sizes of the block.
	localparam int LEGS       = 4;
	localparam int FRAC_BITS  = 16;
	localparam int TIME_W     = 22;
	localparam int TICK_W     = 16;
	localparam int STEP_W     = 16;
	localparam int DUTY_W     = FRAC_BITS + 1;
	localparam int GAIT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int LEG_W      = (LEGS > 1) ? $clog2(LEGS) : 1;
	localparam int CNT_W      = $clog2(FRAC_BITS + 1);
	localparam int PC_W       = 4;
	localparam int UCODE_DEPTH = 1 << PC_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_GAIT_KIND    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_DUTY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RH    = 3'd6;

	// Gait kinds; codes above custom also select the custom registers.
	localparam logic [GAIT_W-1:0] GAIT_TROT   = 3'd0;
	localparam logic [GAIT_W-1:0] GAIT_WALK   = 3'd1;
	localparam logic [GAIT_W-1:0] GAIT_BOUND  = 3'd2;
	localparam logic [GAIT_W-1:0] GAIT_PACE   = 3'd3;
	localparam logic [GAIT_W-1:0] GAIT_STAND  = 3'd4;
	localparam logic [GAIT_W-1:0] GAIT_CUSTOM = 3'd5;

	// Fraction constants.
	localparam logic [DUTY_W-1:0] FRAC_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DUTY_W-1:0] FRAC_HALF    = {2'b01, {(FRAC_BITS-1){1'b0}}};
	localparam logic [DUTY_W-1:0] FRAC_3_4     = {3'b011, {(FRAC_BITS-2){1'b0}}};
	localparam logic [FRAC_BITS-1:0] OFFSET_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

	// Reset values of the registers.
	localparam logic [TIME_W-1:0] CYCLE_LENGTH_RST = 22'd500000;

	// One input word.
	typedef struct packed {
		logic [TICK_W-1:0] tick_time_us;
		logic              restart;
	} tick_t;

	// One result word.
	typedef struct packed {
		logic [STEP_W-1:0]    step_total;
		logic [FRAC_BITS-1:0] cycle_fraction;
		logic                 lf_swing;
		logic [FRAC_BITS-1:0] lf_progress;
		logic                 rf_swing;
		logic [FRAC_BITS-1:0] rf_progress;
		logic                 lh_swing;
		logic [FRAC_BITS-1:0] lh_progress;
		logic                 rh_swing;
		logic [FRAC_BITS-1:0] rh_progress;
	} phase_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [GAIT_W-1:0]                gait_kind;
		logic [TIME_W-1:0]                cycle_length_us;
		logic [DUTY_W-1:0]                custom_duty;
		logic [LEGS-1:0][FRAC_BITS-1:0]   custom_offset;
	} cfg_t;

	// Datapath operations, one per microcode step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_TIMER_ADD,
		OP_TIMER_WRAP,
		OP_FRAC_GO,
		OP_FRAC_PUT,
		OP_LEG_PHASE,
		OP_LEG_GO,
		OP_LEG_PUT,
		OP_EMIT
	} op_t;

	// Jump conditions; a true condition loads the target, else the next step.
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_DIV_BUSY,
		C_MORE_LEGS,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ucode_t;

	// Status from the datapath that the sequencer branches on.
	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic more_legs;
		logic out_full;
	} stat_t;

	// Stance fraction of a preset gait.
	function automatic logic [DUTY_W-1:0] preset_duty(input logic [GAIT_W-1:0] kind);
		logic [DUTY_W-1:0] duty;
		unique case (kind)
			GAIT_WALK:  duty = FRAC_3_4;
			GAIT_STAND: duty = FRAC_ONE;
			default:    duty = FRAC_HALF;
		endcase
		return duty;
	endfunction

	// Phase offset of a leg in a preset gait, in quarters of a cycle.
	function automatic logic [FRAC_BITS-1:0] preset_offset(input logic [GAIT_W-1:0] kind,
			input logic [1:0] slot);
		logic [1:0] quarters;
		unique case (kind)
			GAIT_TROT:  quarters = (slot == 2'd1 || slot == 2'd2) ? 2'd2 : 2'd0;
			GAIT_WALK:  quarters = slot;
			GAIT_BOUND: quarters = slot[1] ? 2'd2 : 2'd0;
			GAIT_PACE:  quarters = slot[0] ? 2'd2 : 2'd0;
			default:    quarters = 2'd0;
		endcase
		return {quarters, {(FRAC_BITS-2){1'b0}}};
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gpg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gait phase generator channels
// Valid/ready channels for tick words in and phase words out.
// ----------------------------------------------------------------------------
interface gpg_tick_if import gpg_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gpg_phase_if import gpg_pkg::*; ();
	logic   valid;
	logic   ready;
	phase_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gpg_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gait phase generator divider
// Restoring divider for a proper fraction: gives floor(num * ONE / den)
// one quotient bit per cycle, or all ones at once when num is not below den.
// ----------------------------------------------------------------------------
module gpg_divider import gpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_W-1:0]    num,
	input  logic [TIME_W-1:0]    den,
	output logic                 busy,
	output logic [FRAC_BITS-1:0] quo
);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [TIME_W:0]      shifted;
	logic [TIME_W+1:0]    diff;
	logic                 fits;
	logic                 too_big;

	// One trial subtraction of the doubled remainder.
	assign shifted = {rem_q, 1'b0};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = !diff[TIME_W+1];
	assign too_big = (num >= den);

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !too_big;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= too_big ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: hw/rtl/gpg_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gait phase generator sequencer
// Step counter over a read-only microcode table; each step names one datapath
// operation and a conditional jump.
// ----------------------------------------------------------------------------
module gpg_sequencer import gpg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output op_t   op
);

	// Step addresses that are jump targets.
	localparam logic [PC_W-1:0] PC_WAIT_IN   = 4'd0;
	localparam logic [PC_W-1:0] PC_FRAC_WAIT = 4'd4;
	localparam logic [PC_W-1:0] PC_LEG_PHASE = 4'd6;
	localparam logic [PC_W-1:0] PC_LEG_WAIT  = 4'd8;
	localparam logic [PC_W-1:0] PC_EMIT      = 4'd10;

	// The program: take a word, update timer, divide for the fraction, then
	// loop over the legs, and hand the result to the output register.
	localparam ucode_t UCODE [UCODE_DEPTH] = '{
		'{OP_ACCEPT,     C_NO_INPUT,  PC_WAIT_IN},
		'{OP_TIMER_ADD,  C_NEXT,      PC_WAIT_IN},
		'{OP_TIMER_WRAP, C_NEXT,      PC_WAIT_IN},
		'{OP_FRAC_GO,    C_NEXT,      PC_WAIT_IN},
		'{OP_NOP,        C_DIV_BUSY,  PC_FRAC_WAIT},
		'{OP_FRAC_PUT,   C_NEXT,      PC_WAIT_IN},
		'{OP_LEG_PHASE,  C_NEXT,      PC_WAIT_IN},
		'{OP_LEG_GO,     C_NEXT,      PC_WAIT_IN},
		'{OP_NOP,        C_DIV_BUSY,  PC_LEG_WAIT},
		'{OP_LEG_PUT,    C_MORE_LEGS, PC_LEG_PHASE},
		'{OP_EMIT,       C_OUT_FULL,  PC_EMIT},
		'{OP_NOP,        C_ALWAYS,    PC_WAIT_IN},
		'{OP_NOP,        C_ALWAYS,    PC_WAIT_IN},
		'{OP_NOP,        C_ALWAYS,    PC_WAIT_IN},
		'{OP_NOP,        C_ALWAYS,    PC_WAIT_IN},
		'{OP_NOP,        C_ALWAYS,    PC_WAIT_IN}
	};

	logic [PC_W-1:0] pc_q;
	ucode_t          word;
	logic            taken;

	assign word = UCODE[pc_q];
	assign op   = word.op;

	// Branch condition decode.
	always_comb begin
		unique case (word.cond)
			C_NEXT:      taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_NO_INPUT:  taken = !stat.in_valid;
			C_DIV_BUSY:  taken = stat.div_busy;
			C_MORE_LEGS: taken = stat.more_legs;
			C_OUT_FULL:  taken = stat.out_full;
			default:     taken = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT_IN;
		end else if (taken) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/gpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gait phase generator datapath
// Cycle timer, step counter, leg phase logic, shared divider and the output
// register, each operation enabled by the current microcode step.
// ----------------------------------------------------------------------------
module gpg_datapath import gpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  op_t                op,
	output stat_t              stat,
	gpg_tick_if.sink           ticks,
	gpg_phase_if.source        phases
);

	logic [TIME_W-1:0]    timer_q;
	logic [STEP_W-1:0]    step_q;
	logic [LEG_W-1:0]     leg_q;
	logic                 out_valid_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 restart_q;
	logic [TIME_W:0]      sum_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [FRAC_BITS-1:0] ph_q;
	logic                 swing_cur_q;
	logic                 swing_q [LEGS];
	logic [FRAC_BITS-1:0] prog_q [LEGS];
	phase_t               out_q;

	logic [TIME_W-1:0]    len;
	logic [TIME_W-1:0]    dt;
	logic [TIME_W-1:0]    base;
	logic                 wrap;
	logic                 custom;
	logic [DUTY_W-1:0]    duty;
	logic [FRAC_BITS-1:0] offset;
	logic                 swing;
	logic [DUTY_W-1:0]    ph_minus_duty;
	logic [FRAC_BITS-1:0] leg_num;
	logic [DUTY_W-1:0]    leg_den;
	logic                 more_legs;
	logic                 out_full;
	logic                 emit;
	logic                 div_start;
	logic [TIME_W-1:0]    div_num;
	logic [TIME_W-1:0]    div_den;
	logic                 div_busy;
	logic [FRAC_BITS-1:0] div_quo;

	// Cycle length, with zero taken as one, and the saturated tick.
	assign len  = (cfg.cycle_length_us == '0) ? TIME_W'(1) : cfg.cycle_length_us;
	assign dt   = (TIME_W'(tick_q) > len) ? len : TIME_W'(tick_q);
	assign base = restart_q ? '0 : timer_q;
	assign wrap = (sum_q >= {1'b0, len});

	// Duty factor and this leg's offset from the preset or the custom registers.
	assign custom = (cfg.gait_kind >= GAIT_CUSTOM);
	always_comb begin
		if (custom) begin
			duty   = (cfg.custom_duty > FRAC_ONE) ? FRAC_ONE : cfg.custom_duty;
			offset = cfg.custom_offset[leg_q];
		end else begin
			duty   = preset_duty(cfg.gait_kind);
			offset = preset_offset(cfg.gait_kind, leg_q);
		end
	end

	// Stance or swing, and the proper fraction to normalize.
	assign swing         = ({1'b0, ph_q} >= duty);
	assign ph_minus_duty = {1'b0, ph_q} - duty;
	assign leg_num       = swing ? ph_minus_duty[FRAC_BITS-1:0] : ph_q;
	assign leg_den       = swing ? (FRAC_ONE - duty) : duty;

	// Shared divider, used once for the cycle fraction and once per leg.
	assign div_start = (op == OP_FRAC_GO) || (op == OP_LEG_GO);
	assign div_num   = (op == OP_FRAC_GO) ? timer_q : TIME_W'(leg_num);
	assign div_den   = (op == OP_FRAC_GO) ? len : TIME_W'(leg_den);

	gpg_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// Handshakes and status for the sequencer.
	assign more_legs = (leg_q != LEG_W'(LEGS - 1));
	assign out_full  = out_valid_q && !phases.ready;
	assign emit      = (op == OP_EMIT) && !out_full;

	assign ticks.ready    = (op == OP_ACCEPT);
	assign stat.in_valid  = ticks.valid;
	assign stat.div_busy  = div_busy;
	assign stat.more_legs = more_legs;
	assign stat.out_full  = out_full;

	assign phases.valid = out_valid_q;
	assign phases.data  = out_q;

	// Timer, step counter, leg index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q     <= '0;
			step_q      <= '0;
			leg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_TIMER_WRAP: begin
					if (wrap) begin
						timer_q <= sum_q[TIME_W-1:0] - len;
						step_q  <= step_q + 1'b1;
					end else begin
						timer_q <= sum_q[TIME_W-1:0];
					end
				end
				OP_FRAC_PUT: leg_q <= '0;
				OP_LEG_PUT: begin
					if (more_legs) begin
						leg_q <= leg_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (phases.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of one word.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_ACCEPT: begin
				if (ticks.valid) begin
					tick_q    <= ticks.data.tick_time_us;
					restart_q <= ticks.data.restart;
				end
			end
			OP_TIMER_ADD: sum_q <= {1'b0, base} + {1'b0, dt};
			OP_FRAC_PUT:  frac_q <= div_quo;
			OP_LEG_PHASE: ph_q <= frac_q + offset;
			OP_LEG_GO:    swing_cur_q <= swing;
			OP_LEG_PUT: begin
				swing_q[leg_q] <= swing_cur_q;
				prog_q[leg_q]  <= div_quo;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.step_total     <= step_q;
			out_q.cycle_fraction <= frac_q;
			out_q.lf_swing       <= swing_q[0];
			out_q.lf_progress    <= prog_q[0];
			out_q.rf_swing       <= swing_q[1];
			out_q.rf_progress    <= prog_q[1];
			out_q.lh_swing       <= swing_q[2];
			out_q.lh_progress    <= prog_q[2];
			out_q.rh_swing       <= swing_q[3];
			out_q.rh_progress    <= prog_q[3];
		end
	end

`ifndef NO_ASSERTIONS
	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while still busy");

	a_div_done_at_put: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FRAC_PUT || op == OP_LEG_PUT) |-> !div_busy)
		else $error("quotient taken before the divider finished");

	a_step_only_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(op != OP_TIMER_WRAP) |=> $stable(step_q))
		else $error("step counter moved outside the wrap step");

	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("output register empty after an emit");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/quadruped_gait_phase_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick word enters when the block is waiting for one; the block then updates
// its cycle timer and step counter and computes the cycle fraction and each
// leg's stance or swing progress. A single shared restoring divider, one
// quotient bit per cycle, serves the five divisions of a word in turn under a
// microcoded sequencer. The result sits in an output register, so the next
// tick word is taken while it waits; a new result is written there only once
// the previous one has been taken.
// Configuration writes take effect at once and belong to idle periods only.
// ----------------------------------------------------------------------------
// Quadruped gait phase generator
// Top level: configuration registers, microcode sequencer and datapath.
// ----------------------------------------------------------------------------
module quadruped_gait_phase_generator import gpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gpg_tick_if.sink              ticks,
	gpg_phase_if.source           phases
);

	cfg_t  cfg_q;
	op_t   op;
	stat_t stat;

	// Configuration register file; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gait_kind        <= GAIT_TROT;
			cfg_q.cycle_length_us  <= CYCLE_LENGTH_RST;
			cfg_q.custom_duty      <= FRAC_HALF;
			cfg_q.custom_offset[0] <= '0;
			cfg_q.custom_offset[1] <= OFFSET_HALF;
			cfg_q.custom_offset[2] <= OFFSET_HALF;
			cfg_q.custom_offset[3] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GAIT_KIND:    cfg_q.gait_kind <= cfg_wdata[GAIT_W-1:0];
				CFG_CYCLE_LENGTH: cfg_q.cycle_length_us <= cfg_wdata[TIME_W-1:0];
				CFG_CUSTOM_DUTY:  cfg_q.custom_duty <= cfg_wdata[DUTY_W-1:0];
				CFG_OFFSET_LF:    cfg_q.custom_offset[0] <= cfg_wdata[FRAC_BITS-1:0];
				CFG_OFFSET_RF:    cfg_q.custom_offset[1] <= cfg_wdata[FRAC_BITS-1:0];
				CFG_OFFSET_LH:    cfg_q.custom_offset[2] <= cfg_wdata[FRAC_BITS-1:0];
				CFG_OFFSET_RH:    cfg_q.custom_offset[3] <= cfg_wdata[FRAC_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	gpg_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	gpg_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.op     (op),
		.stat   (stat),
		.ticks  (ticks),
		.phases (phases)
	);

endmodule
`default_nettype wire
